// File: hdl/rps_pkg.sv
package rps_pkg;
    localparam int SLOT_COUNT_DEF = 4;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_START  = 3'd1;
    localparam logic [2:0] PH_ACTIVE = 3'd2;
    localparam logic [2:0] PH_END    = 3'd3;
    localparam logic [2:0] PH_WAIT   = 3'd4;
    localparam logic [2:0] PH_CHECK  = 3'd5;
    localparam logic [2:0] PH_DONE   = 3'd6;
    localparam logic [2:0] PH_FAIL   = 3'd7;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_BADCH     = 4'd1;
    localparam logic [3:0] ST_POWER     = 4'd2;
    localparam logic [3:0] ST_BUSY      = 4'd3;
    localparam logic [3:0] ST_INTERLOCK = 4'd4;
    localparam logic [3:0] ST_DEBOUNCE  = 4'd5;
    localparam logic [3:0] ST_INTERF    = 4'd6;
    localparam logic [3:0] ST_ALARM     = 4'd7;
    localparam logic [3:0] ST_NOACT     = 4'd8;

    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_EVENT = 3'd1;
    localparam logic [2:0] CMD_OPEN  = 3'd2;
    localparam logic [2:0] CMD_CLOSE = 3'd3;
    localparam logic [2:0] CMD_CLEAR = 3'd4;

    localparam logic [1:0] REL_OFF = 2'd0;
    localparam logic [1:0] REL_ON  = 2'd1;
    localparam logic [1:0] REL_ERR = 2'd2;

    localparam logic [1:0] REG_PULSE = 2'd0;
    localparam logic [1:0] REG_FBDLY = 2'd1;
    localparam logic [1:0] REG_DEBNC = 2'd2;
    localparam logic [1:0] REG_INTWN = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic load;     // latch input word
        logic decide;   // run command decode (event/start/clear)
        logic slot_go;  // advance the slot under the cursor
        logic publish;  // copy status/state to output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_tick;
        logic last_slot;
    } t_sts;
endpackage

// File: hdl/rps_datapath.sv
module rps_datapath #(
    parameter int SLOT_COUNT = rps_pkg::SLOT_COUNT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rps_pkg::t_cmd    i_cmd,
    output rps_pkg::t_sts    o_sts,
    input  logic [2:0]       i_command,
    input  logic [2:0]       i_channel,
    input  logic             i_enable_level,
    input  logic [31:0]      i_now_ms,
    input  logic [8:0]       i_feedback_pins,
    input  logic [2:0]       i_enable_pins,
    input  logic             i_system_alarm,
    input  logic [5:0]       i_contact_alarms,
    input  logic             i_power_alarm,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [15:0]      i_cfg_data,
    output logic [15:0]      o_cfg_rdata,
    output logic [3:0]       o_status,
    output logic [11:0]      o_drive_lines,
    output logic [5:0]       o_channel_states,
    output logic [2:0]       o_busy_mask,
    output logic [31:0]      o_ops_started,
    output logic [31:0]      o_ops_completed,
    output logic [31:0]      o_ops_failed,
    output logic [31:0]      o_interference_count,
    output logic [31:0]      o_filtered_count
);
    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic [15:0] r_pulse, r_fbdly, r_debnc, r_intwn;
    logic [2:0]  r_phase [SLOT_COUNT];
    logic [1:0]  r_sch   [SLOT_COUNT];
    logic        r_sopen [SLOT_COUNT];
    logic [31:0] r_sstart[SLOT_COUNT];
    logic [1:0]  r_rstate[3];
    logic [31:0] r_lacc[3], r_levt[3];
    logic [11:0] r_drive;
    logic [31:0] r_started, r_completed, r_failed, r_interf, r_filtered;
    logic [SW-1:0] r_cur;
    logic [3:0]  r_status;

    // latched input word
    logic [2:0]  r_cmd_in, r_ch_in;
    logic        r_lvl, r_sys, r_pwr;
    logic [31:0] r_now;
    logic [8:0]  r_fb;
    logic [2:0]  r_en;
    logic [5:0]  r_calm;

    // result word, held while the receiver stalls
    logic [3:0]  r_out_status;
    logic [5:0]  r_out_states;
    logic [2:0]  r_out_busy;
    logic [11:0] r_out_drive;
    logic [31:0] r_out_started, r_out_completed, r_out_failed;
    logic [31:0] r_out_interf, r_out_filtered;

    always_comb begin
        case (i_cfg_idx)
            rps_pkg::REG_PULSE: o_cfg_rdata = r_pulse;
            rps_pkg::REG_FBDLY: o_cfg_rdata = r_fbdly;
            rps_pkg::REG_DEBNC: o_cfg_rdata = r_debnc;
            default:            o_cfg_rdata = r_intwn;
        endcase
    end

    // per-channel helpers on latched word
    logic [2:0] busy_vec;
    logic       have_free;
    logic [SW-1:0] free_idx;
    always_comb begin
        busy_vec  = 3'b000;
        have_free = 1'b0;
        free_idx  = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (r_phase[i] == rps_pkg::PH_IDLE) begin
                have_free = 1'b1;
                free_idx  = SW'(i);
            end else if (r_sch[i] != 2'd0) begin
                busy_vec[r_sch[i] - 2'd1] = 1'b1;
            end
        end
    end

    logic       ch_ok;
    logic [1:0] chi;
    logic [2:0] fbc;
    logic       ilock;
    logic [1:0] recent;
    logic       deb_hit;
    logic       alarm;
    always_comb begin
        ch_ok = (r_ch_in != 3'd0) && (r_ch_in <= 3'd3);
        chi   = ch_ok ? 2'(r_ch_in - 3'd1) : 2'd0;
        fbc   = r_fb[3*chi +: 3];
        ilock = 1'b0;
        for (int o = 0; o < 3; o++) begin
            if (o != chi && (!r_en[o] || r_fb[3*o +: 3] != 3'd0)) ilock = 1'b1;
        end
        recent = 2'd0;
        for (int o = 0; o < 3; o++) begin
            if ((r_now - r_levt[o]) < {16'd0, r_intwn}) recent = recent + 2'd1;
        end
        deb_hit = (r_now - r_lacc[chi]) < {16'd0, r_debnc};
        alarm   = r_sys || (r_calm != 6'd0) || r_pwr;
    end

    // slot under cursor
    logic [2:0]  cph;
    logic [1:0]  cch;
    logic        copen;
    logic [31:0] elapsed;
    logic [2:0]  cfb;
    logic [11:0] cmask;
    always_comb begin
        cph     = r_phase[r_cur];
        cch     = r_sch[r_cur];
        copen   = r_sopen[r_cur];
        elapsed = r_now - r_sstart[r_cur];
        cfb     = r_fb[3*(cch - 2'd1) +: 3];
        cmask   = (copen ? 12'h005 : 12'h00A) << (4*(cch - 2'd1));
    end

    assign o_sts.is_tick   = (r_cmd_in == rps_pkg::CMD_TICK);
    assign o_sts.last_slot = (r_cur == SW'(SLOT_COUNT - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse <= 16'd500; r_fbdly <= 16'd500;
            r_debnc <= 16'd50;  r_intwn <= 16'd100;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_phase[i] <= rps_pkg::PH_IDLE; r_sch[i] <= 2'd0;
                r_sopen[i] <= 1'b0; r_sstart[i] <= 32'd0;
            end
            for (int c = 0; c < 3; c++) begin
                r_rstate[c] <= rps_pkg::REL_OFF;
                r_lacc[c] <= 32'd0; r_levt[c] <= 32'd0;
            end
            r_drive <= 12'hFFF;
            r_started <= '0; r_completed <= '0; r_failed <= '0;
            r_interf <= '0; r_filtered <= '0;
            r_cur <= '0; r_status <= rps_pkg::ST_OK;
            r_out_status <= rps_pkg::ST_OK; r_out_states <= '0; r_out_busy <= '0;
            r_out_drive <= 12'hFFF;
            r_out_started <= '0; r_out_completed <= '0; r_out_failed <= '0;
            r_out_interf <= '0; r_out_filtered <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rps_pkg::REG_PULSE: r_pulse <= i_cfg_data;
                    rps_pkg::REG_FBDLY: r_fbdly <= i_cfg_data;
                    rps_pkg::REG_DEBNC: r_debnc <= i_cfg_data;
                    default:            r_intwn <= i_cfg_data;
                endcase
            end
            if (i_cmd.load) begin
                r_cmd_in <= i_command; r_ch_in <= i_channel; r_lvl <= i_enable_level;
                r_now <= i_now_ms; r_fb <= i_feedback_pins; r_en <= i_enable_pins;
                r_sys <= i_system_alarm; r_calm <= i_contact_alarms;
                r_pwr <= i_power_alarm;
                r_cur <= '0;
            end
            if (i_cmd.decide) begin : dec
                logic do_start, is_open;
                do_start = 1'b0; is_open = 1'b0;
                r_status <= rps_pkg::ST_OK;
                case (r_cmd_in)
                    rps_pkg::CMD_TICK: ;
                    rps_pkg::CMD_EVENT: begin
                        if (!ch_ok) begin
                            r_filtered <= r_filtered + 32'd1;
                            r_status <= rps_pkg::ST_BADCH;
                        end else if (deb_hit) begin
                            r_filtered <= r_filtered + 32'd1;
                            r_status <= rps_pkg::ST_DEBOUNCE;
                        end else if (recent >= 2'd2) begin
                            r_filtered <= r_filtered + 32'd1;
                            r_interf <= r_interf + 32'd1;
                            r_status <= rps_pkg::ST_INTERF;
                        end else if (alarm) begin
                            r_status <= rps_pkg::ST_ALARM;
                        end else begin
                            r_lacc[chi] <= r_now; r_levt[chi] <= r_now;
                            if (!r_lvl && fbc != 3'd7) begin
                                do_start = 1'b1; is_open = 1'b1;
                            end else if (r_lvl && fbc == 3'd7) begin
                                do_start = 1'b1;
                            end else begin
                                r_status <= rps_pkg::ST_NOACT;
                            end
                        end
                    end
                    rps_pkg::CMD_OPEN:  begin do_start = 1'b1; is_open = 1'b1; end
                    rps_pkg::CMD_CLOSE: do_start = 1'b1;
                    rps_pkg::CMD_CLEAR: begin
                        if (!ch_ok) r_status <= rps_pkg::ST_BADCH;
                        else if (r_rstate[chi] == rps_pkg::REL_ERR)
                            r_rstate[chi] <= rps_pkg::REL_OFF;
                    end
                    default: r_status <= rps_pkg::ST_NOACT;
                endcase
                if (do_start) begin
                    if (!ch_ok) r_status <= rps_pkg::ST_BADCH;
                    else if (is_open && r_pwr) r_status <= rps_pkg::ST_POWER;
                    else if (busy_vec[chi]) r_status <= rps_pkg::ST_BUSY;
                    else if (is_open && ilock) r_status <= rps_pkg::ST_INTERLOCK;
                    else if (!have_free) r_status <= rps_pkg::ST_BUSY;
                    else begin
                        r_phase[free_idx]  <= rps_pkg::PH_START;
                        r_sch[free_idx]    <= r_ch_in[1:0];
                        r_sopen[free_idx]  <= is_open;
                        r_sstart[free_idx] <= r_now;
                        r_started <= r_started + 32'd1;
                        r_status <= rps_pkg::ST_OK;
                    end
                end
            end
            if (i_cmd.slot_go) begin
                r_cur <= r_cur + SW'(1);
                if (cph != rps_pkg::PH_IDLE) begin
                    if (cch == 2'd0) begin
                        r_phase[r_cur] <= rps_pkg::PH_IDLE;
                    end else begin
                        case (cph)
                            rps_pkg::PH_START: begin
                                r_drive <= r_drive & ~cmask;
                                r_phase[r_cur] <= rps_pkg::PH_ACTIVE;
                                r_sstart[r_cur] <= r_now;
                            end
                            rps_pkg::PH_ACTIVE: if (elapsed >= {16'd0, r_pulse}) begin
                                r_phase[r_cur] <= rps_pkg::PH_END;
                                r_sstart[r_cur] <= r_now;
                            end
                            rps_pkg::PH_END: begin
                                r_drive <= r_drive | cmask;
                                r_phase[r_cur] <= rps_pkg::PH_WAIT;
                                r_sstart[r_cur] <= r_now;
                            end
                            rps_pkg::PH_WAIT: if (elapsed >= {16'd0, r_fbdly}) begin
                                r_phase[r_cur] <= rps_pkg::PH_CHECK;
                                r_sstart[r_cur] <= r_now;
                            end
                            rps_pkg::PH_CHECK: begin
                                if (copen ? (cfb == 3'd7) : (cfb == 3'd0)) begin
                                    r_rstate[cch - 2'd1] <= copen ? rps_pkg::REL_ON
                                                                  : rps_pkg::REL_OFF;
                                    r_phase[r_cur] <= rps_pkg::PH_DONE;
                                    r_completed <= r_completed + 32'd1;
                                end else begin
                                    r_rstate[cch - 2'd1] <= rps_pkg::REL_ERR;
                                    r_phase[r_cur] <= rps_pkg::PH_FAIL;
                                    r_failed <= r_failed + 32'd1;
                                end
                            end
                            default: begin
                                r_phase[r_cur] <= rps_pkg::PH_IDLE;
                                r_sch[r_cur] <= 2'd0;
                            end
                        endcase
                    end
                end
            end
            if (i_cmd.publish) begin
                r_out_status    <= r_status;
                r_out_states    <= {r_rstate[2], r_rstate[1], r_rstate[0]};
                r_out_busy      <= busy_vec;
                r_out_drive     <= r_drive;
                r_out_started   <= r_started;
                r_out_completed <= r_completed;
                r_out_failed    <= r_failed;
                r_out_interf    <= r_interf;
                r_out_filtered  <= r_filtered;
            end
        end
    end

    assign o_status             = r_out_status;
    assign o_channel_states     = r_out_states;
    assign o_busy_mask          = r_out_busy;
    assign o_drive_lines        = r_out_drive;
    assign o_ops_started        = r_out_started;
    assign o_ops_completed      = r_out_completed;
    assign o_ops_failed         = r_out_failed;
    assign o_interference_count = r_out_interf;
    assign o_filtered_count     = r_out_filtered;
endmodule

// File: hdl/rps_ctrl.sv
module rps_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    output rps_pkg::t_cmd o_cmd,
    input  rps_pkg::t_sts i_sts
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_SLOT = 3'd2;
    localparam logic [2:0] S_PUB  = 3'd3;

    logic [2:0] r_state, n_state;
    logic       r_ovalid, n_ovalid;

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid;
        o_cmd    = '0;
        o_stall  = 1'b1;
        if (r_ovalid && !i_stall) n_ovalid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                o_cmd.decide = 1'b1;
                n_state = i_sts.is_tick ? S_SLOT : S_PUB;
            end
            S_SLOT: begin
                o_cmd.slot_go = 1'b1;
                if (i_sts.last_slot) n_state = S_PUB;
            end
            S_PUB: begin
                if (!n_ovalid) begin
                    o_cmd.publish = 1'b1;
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_valid = r_ovalid;
endmodule

// File: hdl/relay_pulse_sequencer_with_interlock_top.sv
// Relay pulse sequencer with interlock for three latching relay channels.
// Input channel: one word per command (tick, enable event, start open,
// start close, clear error), taken when i_valid is high and o_stall low.
// Output channel: one result word per input word, o_valid/i_stall.
// Steps: a non-tick word is loaded, decoded and published; a tick is loaded,
// decoded, walked through every operation slot by a single shared slot
// update unit in slot order, and published.  The next word is taken
// in the cycle after publish, so the output register decouples the sides.
// If the receiver stalls, the whole result word holds; a following word is
// still processed and waits at publish until the output register frees.
// Synchronous active-low reset restores register defaults (500/500/50/100
// ms), idles every slot, sets relays off and all drive lines high.
// APB registers at byte offsets 0,4,8,12; pready is always high.
module relay_pulse_sequencer_with_interlock_top #(
    parameter int SLOT_COUNT = rps_pkg::SLOT_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_command,
    input  logic [2:0]  i_channel,
    input  logic        i_enable_level,
    input  logic [31:0] i_now_ms,
    input  logic [8:0]  i_feedback_pins,
    input  logic [2:0]  i_enable_pins,
    input  logic        i_system_alarm,
    input  logic [5:0]  i_contact_alarms,
    input  logic        i_power_alarm,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_status,
    output logic [11:0] o_drive_lines,
    output logic [5:0]  o_channel_states,
    output logic [2:0]  o_busy_mask,
    output logic [31:0] o_ops_started,
    output logic [31:0] o_ops_completed,
    output logic [31:0] o_ops_failed,
    output logic [31:0] o_interference_count,
    output logic [31:0] o_filtered_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    rps_pkg::t_cmd cmd;
    rps_pkg::t_sts sts;
    logic [15:0]   cfg_rdata;

    assign pready = 1'b1;
    assign prdata = {16'd0, cfg_rdata};

    rps_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_cmd(cmd), .i_sts(sts)
    );

    rps_datapath #(.SLOT_COUNT(SLOT_COUNT)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(cmd), .o_sts(sts),
        .i_command(i_command), .i_channel(i_channel),
        .i_enable_level(i_enable_level), .i_now_ms(i_now_ms),
        .i_feedback_pins(i_feedback_pins), .i_enable_pins(i_enable_pins),
        .i_system_alarm(i_system_alarm), .i_contact_alarms(i_contact_alarms),
        .i_power_alarm(i_power_alarm),
        // paddr[1:0] ignored: word-aligned registers
        .i_cfg_we(psel && penable && pwrite && pready),
        .i_cfg_idx(paddr[3:2]), .i_cfg_data(pwdata[15:0]),
        .o_cfg_rdata(cfg_rdata),
        .o_status(o_status), .o_drive_lines(o_drive_lines),
        .o_channel_states(o_channel_states), .o_busy_mask(o_busy_mask),
        .o_ops_started(o_ops_started), .o_ops_completed(o_ops_completed),
        .o_ops_failed(o_ops_failed), .o_interference_count(o_interference_count),
        .o_filtered_count(o_filtered_count)
    );
endmodule

// File: tb/relay_pulse_sequencer_with_interlock_top_test.sv
module relay_pulse_sequencer_with_interlock_top_test;

    // commands the block does not know
    localparam logic [2:0] CMD_UNDEF5 = 3'd5;
    localparam logic [2:0] CMD_UNDEF7 = 3'd7;
    localparam int NSLOT = rps_pkg::SLOT_COUNT_DEF;
    // drain margin, well above the time a tick takes
    localparam int SETTLE_CYCLES = 4 * (NSLOT + 3);
    // no word moved on either side for this long means the block hung
    localparam int HANG_LIMIT = 4000;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [2:0]  ch;
        logic        lvl;
        logic [31:0] now;
        logic [8:0]  fb;
        logic [2:0]  en;
        logic        sys;
        logic [5:0]  con;
        logic        pwr;
    } t_relay_word;

    typedef struct packed {
        logic [3:0]  status;
        logic [11:0] drive;
        logic [5:0]  states;
        logic [2:0]  busy;
        logic [31:0] started;
        logic [31:0] completed;
        logic [31:0] failed;
        logic [31:0] interf;
        logic [31:0] filtered;
    } t_relay_status;

    // one row of the directed table; chk set where the status is typed in
    typedef struct packed {
        t_relay_word w;
        logic        chk;
        logic [3:0]  st;
    } t_plan_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [2:0]  i_command = '0;
    logic [2:0]  i_channel = '0;
    logic        i_enable_level = 1'b0;
    logic [31:0] i_now_ms = '0;
    logic [8:0]  i_feedback_pins = '0;
    logic [2:0]  i_enable_pins = 3'b111;
    logic        i_system_alarm = 1'b0;
    logic [5:0]  i_contact_alarms = '0;
    logic        i_power_alarm = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [3:0]  o_status;
    logic [11:0] o_drive_lines;
    logic [5:0]  o_channel_states;
    logic [2:0]  o_busy_mask;
    logic [31:0] o_ops_started;
    logic [31:0] o_ops_completed;
    logic [31:0] o_ops_failed;
    logic [31:0] o_interference_count;
    logic [31:0] o_filtered_count;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    relay_pulse_sequencer_with_interlock_top dut (.*);

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Predictor state: slot table, relays, event time stamps, counters
    // ---------------------------------------------------------------
    logic [15:0] pulse_w, fb_delay, debounce, interf_win;
    logic [2:0]  slot_ph [NSLOT];
    logic [1:0]  slot_ch [NSLOT];
    logic        slot_open [NSLOT];
    logic [31:0] slot_t0 [NSLOT];
    logic [1:0]  relay_st [3];
    logic [31:0] last_acc [3];
    logic [31:0] last_evt [3];
    logic [11:0] drive_reg;
    logic [31:0] n_started, n_completed, n_failed, n_interf, n_filtered;

    t_relay_status pending_status [$];
    int errors = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    bit no_gaps = 0;
    int rx_mode = 0;
    int rx_phase = 0;
    logic [31:0] clock_ms = '0;

    function automatic logic [2:0] fb_of(logic [8:0] fb, int c);
        return fb[3*(c-1) +: 3];
    endfunction

    function automatic bit ch_busy(int c);
        for (int i = 0; i < NSLOT; i++)
            if (slot_ph[i] != rps_pkg::PH_IDLE && slot_ch[i] == c) return 1;
        return 0;
    endfunction

    function automatic logic [3:0] start_op(int c, bit open, logic [31:0] now,
                                            logic [8:0] fb, logic [2:0] en,
                                            logic pwr);
        int s;
        s = -1;
        if (c < 1 || c > 3) return rps_pkg::ST_BADCH;
        if (open && pwr) return rps_pkg::ST_POWER;
        if (ch_busy(c)) return rps_pkg::ST_BUSY;
        if (open) begin
            // interlock: any other channel enabled or showing contact
            for (int o = 1; o <= 3; o++)
                if (o != c && (!en[o-1] || fb_of(fb, o) != 3'b000))
                    return rps_pkg::ST_INTERLOCK;
        end
        for (int i = NSLOT - 1; i >= 0; i--)
            if (slot_ph[i] == rps_pkg::PH_IDLE) s = i;
        if (s < 0) return rps_pkg::ST_BUSY;
        slot_ph[s] = rps_pkg::PH_START;
        slot_ch[s] = c[1:0];
        slot_open[s] = open;
        slot_t0[s] = now;
        n_started++;
        return rps_pkg::ST_OK;
    endfunction

    function automatic void set_drive(int c, bit open, bit low);
        logic [11:0] m;
        m = (open ? 12'h5 : 12'hA) << (4 * (c - 1));
        drive_reg = low ? (drive_reg & ~m) : (drive_reg | m);
    endfunction

    function automatic void advance_slots(logic [31:0] now, logic [8:0] fb);
        int c;
        logic [31:0] dt;
        logic [2:0] f;
        for (int i = 0; i < NSLOT; i++) begin
            c = slot_ch[i];
            dt = now - slot_t0[i];
            if (slot_ph[i] == rps_pkg::PH_IDLE) continue;
            if (c == 0) begin
                slot_ph[i] = rps_pkg::PH_IDLE;
                continue;
            end
            case (slot_ph[i])
                rps_pkg::PH_START: begin
                    set_drive(c, slot_open[i], 1);
                    slot_ph[i] = rps_pkg::PH_ACTIVE;
                    slot_t0[i] = now;
                end
                rps_pkg::PH_ACTIVE: if (dt >= {16'd0, pulse_w}) begin
                    slot_ph[i] = rps_pkg::PH_END;
                    slot_t0[i] = now;
                end
                rps_pkg::PH_END: begin
                    set_drive(c, slot_open[i], 0);
                    slot_ph[i] = rps_pkg::PH_WAIT;
                    slot_t0[i] = now;
                end
                rps_pkg::PH_WAIT: if (dt >= {16'd0, fb_delay}) begin
                    slot_ph[i] = rps_pkg::PH_CHECK;
                    slot_t0[i] = now;
                end
                rps_pkg::PH_CHECK: begin
                    f = fb_of(fb, c);
                    if (slot_open[i] ? (f == 3'b111) : (f == 3'b000)) begin
                        relay_st[c-1] = slot_open[i] ? rps_pkg::REL_ON : rps_pkg::REL_OFF;
                        slot_ph[i] = rps_pkg::PH_DONE;
                        n_completed++;
                    end else begin
                        relay_st[c-1] = rps_pkg::REL_ERR;
                        slot_ph[i] = rps_pkg::PH_FAIL;
                        n_failed++;
                    end
                end
                default: begin
                    slot_ph[i] = rps_pkg::PH_IDLE;
                    slot_ch[i] = '0;
                end
            endcase
        end
    endfunction

    function automatic logic [3:0] filter_event(t_relay_word w);
        int c;
        int recent;
        c = w.ch;
        recent = 0;
        if (c < 1 || c > 3) begin
            n_filtered++;
            return rps_pkg::ST_BADCH;
        end
        if (w.now - last_acc[c-1] < {16'd0, debounce}) begin
            n_filtered++;
            return rps_pkg::ST_DEBOUNCE;
        end
        for (int i = 0; i < 3; i++)
            if (w.now - last_evt[i] < {16'd0, interf_win}) recent++;
        if (recent >= 2) begin
            n_interf++;
            n_filtered++;
            return rps_pkg::ST_INTERF;
        end
        if (w.sys || w.con != 6'd0 || w.pwr) return rps_pkg::ST_ALARM;
        last_acc[c-1] = w.now;
        last_evt[c-1] = w.now;
        if (!w.lvl && fb_of(w.fb, c) != 3'b111)
            return start_op(c, 1, w.now, w.fb, w.en, w.pwr);
        if (w.lvl && fb_of(w.fb, c) == 3'b111)
            return start_op(c, 0, w.now, w.fb, w.en, w.pwr);
        return rps_pkg::ST_NOACT;
    endfunction

    function automatic t_relay_status sequence_relays(t_relay_word w);
        t_relay_status r;
        r = '0;
        r.status = rps_pkg::ST_OK;
        case (w.cmd)
            rps_pkg::CMD_TICK:  advance_slots(w.now, w.fb);
            rps_pkg::CMD_EVENT: r.status = filter_event(w);
            rps_pkg::CMD_OPEN:  r.status = start_op(w.ch, 1, w.now, w.fb, w.en, w.pwr);
            rps_pkg::CMD_CLOSE: r.status = start_op(w.ch, 0, w.now, w.fb, w.en, w.pwr);
            rps_pkg::CMD_CLEAR: begin
                if (w.ch >= 1 && w.ch <= 3) begin
                    if (relay_st[w.ch-1] == rps_pkg::REL_ERR)
                        relay_st[w.ch-1] = rps_pkg::REL_OFF;
                end else begin
                    r.status = rps_pkg::ST_BADCH;
                end
            end
            default: r.status = rps_pkg::ST_NOACT;
        endcase
        for (int c = 1; c <= 3; c++) begin
            r.states[2*(c-1) +: 2] = relay_st[c-1];
            r.busy[c-1] = ch_busy(c);
        end
        r.drive = drive_reg;
        r.started = n_started;
        r.completed = n_completed;
        r.failed = n_failed;
        r.interf = n_interf;
        r.filtered = n_filtered;
        return r;
    endfunction

    function automatic void reset_model();
        pulse_w = 16'd500;
        fb_delay = 16'd500;
        debounce = 16'd50;
        interf_win = 16'd100;
        for (int i = 0; i < NSLOT; i++) begin
            slot_ph[i] = rps_pkg::PH_IDLE;
            slot_ch[i] = '0;
            slot_open[i] = 0;
            slot_t0[i] = '0;
        end
        for (int c = 0; c < 3; c++) begin
            relay_st[c] = rps_pkg::REL_OFF;
            last_acc[c] = '0;
            last_evt[c] = '0;
        end
        drive_reg = 12'hFFF;
        n_started = '0;
        n_completed = '0;
        n_failed = '0;
        n_interf = '0;
        n_filtered = '0;
    endfunction

    // ---------------------------------------------------------------
    // Result side: stall pattern and checking
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        // receiver changes its habit now and then: never, random, periodic
        if ($urandom_range(0, 299) == 0) rx_mode = $urandom_range(0, 2);
        rx_phase = (rx_phase + 1) % 7;
        case (rx_mode)
            0: i_stall = 1'b0;
            1: i_stall = ($urandom_range(0, 2) == 0);
            default: i_stall = (rx_phase < 3);
        endcase
    end

    always @(posedge i_clk) begin
        t_relay_status got, want;
        got = '{o_status, o_drive_lines, o_channel_states, o_busy_mask,
                o_ops_started, o_ops_completed, o_ops_failed,
                o_interference_count, o_filtered_count};
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_status.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word %p", got);
            end else begin
                want = pending_status.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10) $display("mismatch: want %p got %p", want, got);
                end
            end
        end
        if (idle_cycles >= HANG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Command side
    // ---------------------------------------------------------------
    task automatic send_word(t_relay_word w, logic chk, logic [3:0] st);
        t_relay_status r;
        @(negedge i_clk);
        if (!no_gaps && burst_left == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        if (burst_left > 0) burst_left--;
        {i_command, i_channel, i_enable_level, i_now_ms, i_feedback_pins,
         i_enable_pins, i_system_alarm, i_contact_alarms, i_power_alarm} = w;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        r = sequence_relays(w);
        if (chk) r.status = st;
        pending_status.push_back(r);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] v);
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = {16'd0, v};
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            rps_pkg::REG_PULSE: pulse_w = v;
            rps_pkg::REG_FBDLY: fb_delay = v;
            rps_pkg::REG_DEBNC: debounce = v;
            default:            interf_win = v;
        endcase
        // read back
        psel = 1'b1;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        if (prdata[15:0] !== v) begin
            errors++;
            if (errors <= 10) $display("reg %0d read %h, want %h", idx, prdata, v);
        end
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_timing(logic [15:0] pw, logic [15:0] fd, logic [15:0] db,
                              logic [15:0] iw);
        write_reg(rps_pkg::REG_PULSE, pw);
        write_reg(rps_pkg::REG_FBDLY, fd);
        write_reg(rps_pkg::REG_DEBNC, db);
        write_reg(rps_pkg::REG_INTWN, iw);
    endtask

    // Random word: mostly well-formed traffic (clean alarms, idle enable
    // pins, feedback mostly all-open or all-closed per channel), some noise on top.
    function automatic t_relay_word make_word(int span);
        t_relay_word w;
        int pick;
        pick = $urandom_range(0, 99);
        w.cmd = (pick < 45) ? rps_pkg::CMD_TICK : (pick < 67) ? rps_pkg::CMD_EVENT :
                (pick < 79) ? rps_pkg::CMD_OPEN : (pick < 89) ? rps_pkg::CMD_CLOSE :
                (pick < 96) ? rps_pkg::CMD_CLEAR : 3'($urandom_range(5, 7));
        w.ch = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(0, 7))
                                            : 3'($urandom_range(1, 3));
        w.lvl = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 3) clock_ms = $urandom;
        else if (pick < 10) clock_ms += $urandom_range(0, 70000);
        else clock_ms += $urandom_range(0, span);
        w.now = clock_ms;
        for (int c = 0; c < 3; c++) begin
            pick = $urandom_range(0, 9);
            w.fb[3*c +: 3] = (pick < 5) ? 3'b000 : (pick < 9) ? 3'b111 : 3'($urandom);
        end
        // events and opens on a quiet neighbourhood get past the interlock
        if (w.cmd != rps_pkg::CMD_TICK && $urandom_range(0, 1) == 0)
            for (int c = 1; c <= 3; c++)
                if (c != w.ch) w.fb[3*(c-1) +: 3] = 3'b000;
        w.en = ($urandom_range(0, 5) == 0) ? 3'($urandom) : 3'b111;
        w.sys = ($urandom_range(0, 19) == 0);
        w.con = ($urandom_range(0, 19) == 0) ? 6'($urandom) : 6'd0;
        w.pwr = ($urandom_range(0, 19) == 0);
        return w;
    endfunction

    task automatic random_phase(int n, int span);
        repeat (n) send_word(make_word(span), 1'b0, rps_pkg::ST_OK);
    endtask

    initial begin
        t_plan_row plan [$];
        reset_model();
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part, register defaults after reset
        plan = '{
            '{'{rps_pkg::CMD_TICK, 3'd1, 1'b0, 32'd0, 9'o000, 3'b111, 1'b0, 6'd0, 1'b0},
              1'b1, rps_pkg::ST_OK},
            '{'{CMD_UNDEF5, 3'd1, 1'b0, 32'd0, 9'o000, 3'b111, 1'b0, 6'd0, 1'b0},
              1'b1, rps_pkg::ST_NOACT},
            '{'{CMD_UNDEF7, 3'd2, 1'b1, 32'hFFFF_FFFF, 9'o777, 3'b000, 1'b1, 6'h3F, 1'b1},
              1'b1, rps_pkg::ST_NOACT},
            '{'{rps_pkg::CMD_EVENT, 3'd0, 1'b0, 32'd1000, 9'o000, 3'b111, 1'b0, 6'd0, 1'b0},
              1'b1, rps_pkg::ST_BADCH},
            '{'{rps_pkg::CMD_EVENT, 3'd7, 1'b1, 32'd1000, 9'o000, 3'b111, 1'b0, 6'd0, 1'b0},
              1'b1, rps_pkg::ST_BADCH},
            '{'{rps_pkg::CMD_OPEN, 3'd4, 1'b0, 32'd1000, 9'o000, 3'b111, 1'b0, 6'd0, 1'b0},
              1'b1, rps_pkg::ST_BADCH},
            '{'{rps_pkg::CMD_CLEAR, 3'd0, 1'b0, 32'd1000, 9'o000, 3'b111, 1'b0, 6'd0, 1'b0},
              1'b1, rps_pkg::ST_BADCH},
            // inside the debounce window of the reset time stamp
            '{'{rps_pkg::CMD_EVENT, 3'd1, 1'b0, 32'd10, 9'o000, 3'b111, 1'b0, 6'd0, 1'b0},
              1'b1, rps_pkg::ST_DEBOUNCE},
            // each alarm on its own blocks an event
            '{'{rps_pkg::CMD_EVENT, 3'd1, 1'b0, 32'd1000, 9'o000, 3'b111, 1'b1, 6'd0, 1'b0},
              1'b1, rps_pkg::ST_ALARM},
            '{'{rps_pkg::CMD_EVENT, 3'd1, 1'b0, 32'd1000, 9'o000, 3'b111, 1'b0, 6'h3F, 1'b0},
              1'b1, rps_pkg::ST_ALARM},
            '{'{rps_pkg::CMD_EVENT, 3'd1, 1'b0, 32'd1000, 9'o000, 3'b111, 1'b0, 6'd0, 1'b1},
              1'b1, rps_pkg::ST_ALARM},
            '{'{rps_pkg::CMD_EVENT, 3'd1, 1'b0, 32'd1000, 9'o000, 3'b111, 1'b0, 6'd0, 1'b0},
              1'b1, rps_pkg::ST_OK},
            '{'{rps_pkg::CMD_EVENT, 3'd2, 1'b1, 32'd1010, 9'o070, 3'b111, 1'b0, 6'd0, 1'b0},
              1'b0, rps_pkg::ST_OK},
            // two channels seen within the window
            '{'{rps_pkg::CMD_EVENT, 3'd3, 1'b0, 32'd1020, 9'o000, 3'b111, 1'b0, 6'd0, 1'b0},
              1'b1, rps_pkg::ST_INTERF},
            '{'{rps_pkg::CMD_OPEN, 3'd1, 1'b0, 32'd1030, 9'o000, 3'b111, 1'b0, 6'd0, 1'b0},
              1'b1, rps_pkg::ST_BUSY},
            '{'{rps_pkg::CMD_OPEN, 3'd3, 1'b0, 32'd1030, 9'o000, 3'b111, 1'b0, 6'd0, 1'b1},
              1'b1, rps_pkg::ST_POWER},
            '{'{rps_pkg::CMD_OPEN, 3'd3, 1'b0, 32'd1030, 9'o000, 3'b110, 1'b0, 6'd0, 1'b0},
              1'b1, rps_pkg::ST_INTERLOCK},
            '{'{rps_pkg::CMD_CLOSE, 3'd3, 1'b1, 32'd1030, 9'o000, 3'b111, 1'b0, 6'd0, 1'b0},
              1'b0, rps_pkg::ST_OK},
            // walk all three slots through pulse, wait and check
            '{'{rps_pkg::CMD_TICK, 3'd0, 1'b0, 32'd1040, 9'o000, 3'b111, 1'b0, 6'd0, 1'b0},
              1'b0, rps_pkg::ST_OK},
            '{'{rps_pkg::CMD_TICK, 3'd0, 1'b0, 32'd1600, 9'o000, 3'b111, 1'b0, 6'd0, 1'b0},
              1'b0, rps_pkg::ST_OK},
            '{'{rps_pkg::CMD_TICK, 3'd0, 1'b0, 32'd1601, 9'o000, 3'b111, 1'b0, 6'd0, 1'b0},
              1'b0, rps_pkg::ST_OK},
            '{'{rps_pkg::CMD_TICK, 3'd0, 1'b0, 32'd2200, 9'o000, 3'b111, 1'b0, 6'd0, 1'b0},
              1'b0, rps_pkg::ST_OK},
            // channel 1 reports closed contacts, channel 3 a mixed reading: one fails
            '{'{rps_pkg::CMD_TICK, 3'd0, 1'b0, 32'd2201, 9'o507, 3'b111, 1'b0, 6'd0, 1'b0},
              1'b0, rps_pkg::ST_OK},
            '{'{rps_pkg::CMD_TICK, 3'd0, 1'b0, 32'd2202, 9'o000, 3'b111, 1'b0, 6'd0, 1'b0},
              1'b0, rps_pkg::ST_OK},
            '{'{rps_pkg::CMD_EVENT, 3'd2, 1'b0, 32'd5000, 9'o070, 3'b111, 1'b0, 6'd0, 1'b0},
              1'b1, rps_pkg::ST_NOACT},
            '{'{rps_pkg::CMD_CLEAR, 3'd3, 1'b0, 32'd5000, 9'o000, 3'b111, 1'b0, 6'd0, 1'b0},
              1'b1, rps_pkg::ST_OK}
        };
        foreach (plan[i]) send_word(plan[i].w, plan[i].chk, plan[i].st);
        drain();

        // random phases over several timing settings, extremes included
        clock_ms = 32'd10000;
        random_phase(300, 200);
        drain();
        set_timing(16'd1, 16'd0, 16'd0, 16'd0);
        no_gaps = 1;
        random_phase(320, 3);
        drain();
        no_gaps = 0;
        set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        random_phase(300, 40000);
        drain();
        set_timing(16'($urandom_range(1, 20)), 16'($urandom_range(0, 20)),
                   16'($urandom_range(0, 30)), 16'($urandom_range(0, 40)));
        random_phase(320, 15);
        drain();
        set_timing(16'd3, 16'd5, 16'd10, 16'd200);
        random_phase(300, 60);
        drain();

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
